/* src/swa_pkg.sv */
package swa_pkg;

    // Sizing of the sample store and the arithmetic.
    localparam int WINDOW_MAX  = 64;
    localparam int SAMPLE_BITS = 16;
    localparam int IDX_W       = $clog2(WINDOW_MAX);
    localparam int CNT_W       = $clog2(WINDOW_MAX + 1);
    localparam int SUM_W       = SAMPLE_BITS + IDX_W;
    localparam int WIN_CFG_W   = 7;
    localparam int WIN_RESET   = 16;

    // Item operation codes.
    localparam logic OP_PUSH  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Average reported while the store holds no sample (-1.0 in Q8.8).
    localparam logic signed [SAMPLE_BITS-1:0] EMPTY_MARK = SAMPLE_BITS'(-256);

    typedef struct packed {
        logic                          opcode;
        logic signed [SAMPLE_BITS-1:0] sample;
    } swa_in_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] average;
        logic                          empty_res;
    } swa_out_t;

    // Commands from the sequencer to the sample store.
    typedef struct packed {
        logic clear;
        logic rd_en;
        logic upd_en;
    } swa_store_cmd_t;

    // Store status seen by the sequencer.
    typedef struct packed {
        logic [CNT_W-1:0]        count;
        logic signed [SUM_W-1:0] sum;
    } swa_store_stat_t;

    // Saturate the written window length into the range 1 .. WINDOW_MAX.
    function automatic logic [CNT_W-1:0] eff_window(input logic [WIN_CFG_W-1:0] wl);
        logic [CNT_W-1:0] res;
        if (wl == '0) begin
            res = CNT_W'(1);
        end else if (int'(wl) > WINDOW_MAX) begin
            res = CNT_W'(WINDOW_MAX);
        end else begin
            res = CNT_W'(wl);
        end
        return res;
    endfunction

endpackage

/* src/swa_store.sv */
module swa_store (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  swa_pkg::swa_store_cmd_t              cmd,
    input  logic signed [swa_pkg::SAMPLE_BITS-1:0] sample,
    input  logic [swa_pkg::CNT_W-1:0]            win,
    output swa_pkg::swa_store_stat_t             stat
);

    logic signed [swa_pkg::SAMPLE_BITS-1:0] ring [swa_pkg::WINDOW_MAX];
    logic signed [swa_pkg::SAMPLE_BITS-1:0] old_reg;
    logic [swa_pkg::IDX_W-1:0]              ptr_reg, ptr_next;
    logic [swa_pkg::CNT_W-1:0]              count_reg, count_next;
    logic signed [swa_pkg::SUM_W-1:0]       sum_reg, sum_next;
    logic                                   full;
    logic [swa_pkg::IDX_W-1:0]              wr_addr;
    logic signed [swa_pkg::SUM_W-1:0]       drop;

    assign full    = (count_reg >= win);
    assign wr_addr = full ? ptr_reg : count_reg[swa_pkg::IDX_W-1:0];
    assign drop    = full ? swa_pkg::SUM_W'(old_reg) : '0;

    // Next pointer, count and sum for a pushed sample.
    always_comb begin
        ptr_next   = ptr_reg;
        count_next = count_reg;
        sum_next   = sum_reg;
        if (cmd.clear) begin
            ptr_next   = '0;
            count_next = '0;
            sum_next   = '0;
        end else if (cmd.upd_en) begin
            sum_next = sum_reg + swa_pkg::SUM_W'(sample) - drop;
            if (full) begin
                if (swa_pkg::CNT_W'(ptr_reg) + swa_pkg::CNT_W'(1) == win) begin
                    ptr_next = '0;
                end else begin
                    ptr_next = ptr_reg + swa_pkg::IDX_W'(1);
                end
            end else begin
                count_next = count_reg + swa_pkg::CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ptr_reg   <= '0;
            count_reg <= '0;
            sum_reg   <= '0;
        end else begin
            ptr_reg   <= ptr_next;
            count_reg <= count_next;
            sum_reg   <= sum_next;
        end
    end

    // Sample memory: the oldest entry is read when an item is taken in,
    // and the new sample is written in the cycle after.
    always_ff @(posedge aclk) begin
        if (cmd.rd_en) begin
            old_reg <= ring[ptr_reg];
        end
        if (cmd.upd_en && !cmd.clear) begin
            ring[wr_addr] <= sample;
        end
    end

    assign stat.count = count_reg;
    assign stat.sum   = sum_reg;

endmodule

/* src/swa_divider.sv */
module swa_divider (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [swa_pkg::SUM_W-1:0]     dividend,
    input  logic [swa_pkg::CNT_W-1:0]     divisor,
    output logic                          done,
    output logic [swa_pkg::SUM_W-1:0]     quotient
);

    localparam int STEP_W = $clog2(swa_pkg::SUM_W);

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [STEP_W-1:0]             step_reg, step_next;
    logic [swa_pkg::CNT_W-1:0]     rem_reg, rem_next;
    logic [swa_pkg::SUM_W-1:0]     qd_reg, qd_next;
    logic [swa_pkg::CNT_W-1:0]     dvs_reg, dvs_next;
    logic [swa_pkg::CNT_W:0]       shifted;
    logic [swa_pkg::CNT_W+1:0]     diff;

    // One restoring step: shift in the next dividend bit and try a subtract.
    assign shifted = {rem_reg, qd_reg[swa_pkg::SUM_W-1]};
    assign diff    = {1'b0, shifted} - {2'b00, dvs_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        qd_next   = qd_reg;
        dvs_next  = dvs_reg;
        if (start) begin
            busy_next = 1'b1;
            step_next = '0;
            rem_next  = '0;
            qd_next   = dividend;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            if (diff[swa_pkg::CNT_W+1]) begin
                rem_next = shifted[swa_pkg::CNT_W-1:0];
                qd_next  = {qd_reg[swa_pkg::SUM_W-2:0], 1'b0};
            end else begin
                rem_next = diff[swa_pkg::CNT_W-1:0];
                qd_next  = {qd_reg[swa_pkg::SUM_W-2:0], 1'b1};
            end
            if (step_reg == STEP_W'(swa_pkg::SUM_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                step_next = step_reg + STEP_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        qd_reg  <= qd_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = qd_reg;

endmodule

/* src/sliding_window_average.sv */
// A push, or a query on a non-empty store, goes through the bit-serial divider;
// a query on an empty store does not and reports the empty marker.
// The sequencer holds a single item until its result transfer completes, so
// no new item is taken in before then.
// Reset: synchronous, active low; the window length returns to 16 and the store
// is empty at once (count and sum cleared, no clearing pass over the memory).
module sliding_window_average (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_wr_en,
    input  logic [swa_pkg::WIN_CFG_W-1:0]         cfg_wr_data,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  swa_pkg::swa_in_t                      s_payload,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output swa_pkg::swa_out_t                     m_payload
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_UPD  = 3'd1;
    localparam logic [2:0] ST_CALC = 3'd2;
    localparam logic [2:0] ST_WAIT = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0]                             state_reg, state_next;
    logic [swa_pkg::CNT_W-1:0]              win_reg;
    logic signed [swa_pkg::SAMPLE_BITS-1:0] sample_reg;
    logic                                   neg_reg;
    swa_pkg::swa_out_t                      out_reg, out_next;
    swa_pkg::swa_store_cmd_t                cmd;
    swa_pkg::swa_store_stat_t               stat;
    logic                                   s_xfer;
    logic                                   div_start;
    logic                                   div_done;
    logic [swa_pkg::SUM_W-1:0]              magnitude;
    logic [swa_pkg::SUM_W-1:0]              quotient;
    logic [swa_pkg::SUM_W-1:0]              signed_quo;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = (state_reg == ST_OUT);
    assign m_payload = out_reg;
    assign s_xfer  = s_valid && s_ready;

    // Effective window length, saturated on each write.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg <= swa_pkg::eff_window(swa_pkg::WIN_CFG_W'(swa_pkg::WIN_RESET));
        end else if (cfg_wr_en) begin
            win_reg <= swa_pkg::eff_window(cfg_wr_data);
        end
    end

    // Store commands: read the oldest sample on the input transfer, update next cycle.
    assign cmd.clear  = cfg_wr_en;
    assign cmd.rd_en  = s_xfer;
    assign cmd.upd_en = (state_reg == ST_UPD);

    swa_store u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .sample  (sample_reg),
        .win     (win_reg),
        .stat    (stat)
    );

    // The divider works on the magnitude of the sum; the sign is applied after.
    assign magnitude = stat.sum[swa_pkg::SUM_W-1] ? (~stat.sum + swa_pkg::SUM_W'(1))
                                                  : stat.sum;
    assign div_start = (state_reg == ST_CALC) && (stat.count != '0);

    swa_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (magnitude),
        .divisor  (stat.count),
        .done     (div_done),
        .quotient (quotient)
    );

    assign signed_quo = neg_reg ? (~quotient + swa_pkg::SUM_W'(1)) : quotient;

    // Item sequencer.
    always_comb begin
        state_next = state_reg;
        out_next   = out_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_xfer) begin
                    state_next = (s_payload.opcode == swa_pkg::OP_PUSH) ? ST_UPD : ST_CALC;
                end
            end
            ST_UPD: begin
                state_next = ST_CALC;
            end
            ST_CALC: begin
                if (stat.count == '0) begin
                    out_next.average   = swa_pkg::EMPTY_MARK;
                    out_next.empty_res = 1'b1;
                    state_next         = ST_OUT;
                end else begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (div_done) begin
                    out_next.average   = signed_quo[swa_pkg::SAMPLE_BITS-1:0];
                    out_next.empty_res = 1'b0;
                    state_next         = ST_OUT;
                end
            end
            ST_OUT: begin
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Item and result holding registers.
    always_ff @(posedge aclk) begin
        out_reg <= out_next;
        if (s_xfer) begin
            sample_reg <= s_payload.sample;
        end
        if (div_start) begin
            neg_reg <= stat.sum[swa_pkg::SUM_W-1];
        end
    end

    // The block never offers a result while it takes in an item.
    assert property (@(posedge aclk) disable iff (!aresetn) !(s_ready && m_valid))
        else $error("input and result channels active together");

    // The held count never exceeds the effective window.
    assert property (@(posedge aclk) disable iff (!aresetn) stat.count <= win_reg)
        else $error("held count above window length");

    // An empty result always carries the -1.0 marker.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_payload.empty_res) |-> (m_payload.average == swa_pkg::EMPTY_MARK))
        else $error("empty result without marker");

    // After an input transfer the block is busy in the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn) s_xfer |=> !s_ready)
        else $error("ready held high after input transfer");

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int ITEMS_PER_SEGMENT = 100;

    logic                           aclk;
    logic                           aresetn;
    logic                           cfg_wr_en;
    logic [swa_pkg::WIN_CFG_W-1:0]  cfg_wr_data;
    logic                           s_valid;
    logic                           s_ready;
    swa_pkg::swa_in_t               s_payload;
    logic                           m_valid;
    logic                           m_ready;
    swa_pkg::swa_out_t              m_payload;

    // Idle percentages for the two sides and the receiver hold-off length.
    int unsigned src_idle_pct;
    int unsigned dst_stall_pct;
    int unsigned rx_hold_len;
    int unsigned cycle_count;
    int unsigned error_count;

    // Mirror of the block's window and sample store.
    logic [swa_pkg::WIN_CFG_W-1:0]          win_len;
    logic signed [swa_pkg::SAMPLE_BITS-1:0] ring [swa_pkg::WINDOW_MAX];
    int unsigned                            oldest;
    int unsigned                            held;
    longint                                 run_sum;

    // Averages still owed by the block, oldest first.
    swa_pkg::swa_out_t avg_q [$];

    sliding_window_average u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_payload   (s_payload),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_payload   (m_payload)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    // Watchdog for a hung handshake.
    initial begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

    // A window length of zero means one sample; anything above the store size saturates.
    function automatic int unsigned window_span();
        int unsigned span;
        span = int'(win_len);
        if (span == 0) begin
            span = 1;
        end else if (span > swa_pkg::WINDOW_MAX) begin
            span = swa_pkg::WINDOW_MAX;
        end
        return span;
    endfunction

    task automatic set_window(input logic [swa_pkg::WIN_CFG_W-1:0] len);
        win_len = len;
        oldest  = 0;
        held    = 0;
        run_sum = 0;
    endtask

    // Update the mirrored store with one item and work out the mean it reports.
    task automatic predict_average(input swa_pkg::swa_in_t item,
                                   output swa_pkg::swa_out_t res);
        int unsigned span;
        int unsigned slot;
        span = window_span();
        if (item.opcode == swa_pkg::OP_PUSH) begin
            if (held >= span) begin
                slot       = oldest % span;
                run_sum    = run_sum - ring[slot];
                ring[slot] = item.sample;
                run_sum    = run_sum + item.sample;
                oldest     = (slot + 1) % span;
                held       = span;
            end else begin
                slot       = (oldest + held) % span;
                ring[slot] = item.sample;
                run_sum    = run_sum + item.sample;
                held       = held + 1;
            end
        end
        if (held == 0) begin
            res.average   = swa_pkg::EMPTY_MARK;
            res.empty_res = 1'b1;
        end else begin
            res.average   = swa_pkg::SAMPLE_BITS'(run_sum / longint'(held));
            res.empty_res = 1'b0;
        end
    endtask

    // Track register writes and input transfers, and check every result transfer.
    always @(posedge aclk) begin : scoreboard
        swa_pkg::swa_out_t want;
        swa_pkg::swa_out_t got;
        if (aresetn) begin
            if (cfg_wr_en) begin
                set_window(cfg_wr_data);
            end
            if (s_valid && s_ready) begin
                predict_average(s_payload, want);
                avg_q.push_back(want);
            end
            if (m_valid && m_ready) begin
                got = m_payload;
                if (avg_q.size() == 0) begin
                    $display("%0t: unexpected result: expected none, actual average %0d empty %0b",
                             $time, got.average, got.empty_res);
                    error_count++;
                end else begin
                    want = avg_q.pop_front();
                    if (got.average !== want.average) begin
                        $display("%0t: average mismatch: expected %0d, actual %0d",
                                 $time, want.average, got.average);
                        error_count++;
                    end
                    if (got.empty_res !== want.empty_res) begin
                        $display("%0t: empty flag mismatch: expected %0b, actual %0b",
                                 $time, want.empty_res, got.empty_res);
                        error_count++;
                    end
                end
            end
        end
    end

    // The receiver stalls at random, or holds off entirely while a hold-off is pending.
    always @(negedge aclk) begin : receiver
        if (rx_hold_len != 0) begin
            rx_hold_len = rx_hold_len - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= dst_stall_pct);
        end
    end

    // Offer one item, with random idle cycles first, and wait for its transfer.
    task automatic send_item(input logic op,
                             input logic signed [swa_pkg::SAMPLE_BITS-1:0] smp);
        swa_pkg::swa_in_t item;
        item.opcode = op;
        item.sample = smp;
        @(negedge aclk);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_payload <= item;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Stop offering and wait until every expected average has come back.
    task automatic wait_results_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (avg_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // A new window length is written only once the block is idle.
    task automatic write_window_length(input logic [swa_pkg::WIN_CFG_W-1:0] len);
        wait_results_drained();
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= len;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    function automatic logic signed [swa_pkg::SAMPLE_BITS-1:0] pick_sample();
        logic signed [swa_pkg::SAMPLE_BITS-1:0] v;
        case ($urandom_range(7))
            0:       v = {1'b1, {(swa_pkg::SAMPLE_BITS-1){1'b0}}};
            1:       v = {1'b0, {(swa_pkg::SAMPLE_BITS-1){1'b1}}};
            2:       v = swa_pkg::EMPTY_MARK + swa_pkg::SAMPLE_BITS'($urandom_range(8))
                         - swa_pkg::SAMPLE_BITS'(4);
            default: v = swa_pkg::SAMPLE_BITS'($urandom());
        endcase
        return v;
    endfunction

    function automatic logic [swa_pkg::WIN_CFG_W-1:0] pick_window();
        logic [swa_pkg::WIN_CFG_W-1:0] v;
        case ($urandom_range(6))
            0:       v = '0;
            1:       v = swa_pkg::WIN_CFG_W'(1);
            2:       v = swa_pkg::WIN_CFG_W'(swa_pkg::WINDOW_MAX);
            3:       v = swa_pkg::WIN_CFG_W'($urandom_range(2 ** swa_pkg::WIN_CFG_W - 1,
                                                            swa_pkg::WINDOW_MAX + 1));
            4:       v = swa_pkg::WIN_CFG_W'($urandom_range(swa_pkg::WINDOW_MAX - 1, 9));
            default: v = swa_pkg::WIN_CFG_W'($urandom_range(8, 2));
        endcase
        return v;
    endfunction

    // Empty store after reset, then the full sample range under the reset window.
    task automatic test_reset_window();
        send_item(swa_pkg::OP_QUERY, '0);
        send_item(swa_pkg::OP_PUSH, {1'b0, {(swa_pkg::SAMPLE_BITS-1){1'b1}}});
        send_item(swa_pkg::OP_PUSH, {1'b1, {(swa_pkg::SAMPLE_BITS-1){1'b0}}});
        send_item(swa_pkg::OP_QUERY, {(swa_pkg::SAMPLE_BITS){1'b1}});
        send_item(swa_pkg::OP_PUSH, swa_pkg::SAMPLE_BITS'(-1));
    endtask

    // Window edge cases: one sample, zero, saturation, the -1.0 mean, truncation.
    task automatic test_window_edges();
        write_window_length(swa_pkg::WIN_CFG_W'(1));
        send_item(swa_pkg::OP_QUERY, '0);
        send_item(swa_pkg::OP_PUSH, swa_pkg::SAMPLE_BITS'(100));
        send_item(swa_pkg::OP_PUSH, swa_pkg::SAMPLE_BITS'(-3));
        send_item(swa_pkg::OP_QUERY, '0);
        write_window_length('0);
        send_item(swa_pkg::OP_PUSH, swa_pkg::SAMPLE_BITS'(5));
        send_item(swa_pkg::OP_PUSH, swa_pkg::SAMPLE_BITS'(7));
        write_window_length({swa_pkg::WIN_CFG_W{1'b1}});
        send_item(swa_pkg::OP_PUSH, swa_pkg::EMPTY_MARK);
        send_item(swa_pkg::OP_QUERY, '0);
        write_window_length(swa_pkg::WIN_CFG_W'(swa_pkg::WINDOW_MAX));
        send_item(swa_pkg::OP_PUSH, swa_pkg::SAMPLE_BITS'(-3));
        send_item(swa_pkg::OP_PUSH, swa_pkg::SAMPLE_BITS'(-2));
        send_item(swa_pkg::OP_PUSH, swa_pkg::SAMPLE_BITS'(-250));
        send_item(swa_pkg::OP_QUERY, '0);
    endtask

    // Random windows and mostly pushes, under the given idling on both sides.
    task automatic test_random_traffic(input int unsigned src_pct, input int unsigned dst_pct);
        logic op;
        src_idle_pct  = src_pct;
        dst_stall_pct = dst_pct;
        for (int seg = 0; seg < 4; seg++) begin
            write_window_length(pick_window());
            for (int n = 0; n < ITEMS_PER_SEGMENT; n++) begin
                op = ($urandom_range(99) < 20) ? swa_pkg::OP_QUERY : swa_pkg::OP_PUSH;
                send_item(op, pick_sample());
            end
        end
    endtask

    // The receiver holds off long enough that the input stalls; then the sender
    // waits for every result before going on.
    task automatic test_backpressure();
        src_idle_pct  = 0;
        dst_stall_pct = 0;
        write_window_length(swa_pkg::WIN_CFG_W'(4));
        rx_hold_len = 300;
        for (int n = 0; n < 8; n++) begin
            send_item(swa_pkg::OP_PUSH, pick_sample());
        end
        wait_results_drained();
        for (int n = 0; n < 10; n++) begin
            send_item((n % 3 == 2) ? swa_pkg::OP_QUERY : swa_pkg::OP_PUSH, pick_sample());
        end
    endtask

    initial begin
        aresetn       = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = '0;
        s_valid       = 1'b0;
        s_payload     = '0;
        m_ready       = 1'b0;
        src_idle_pct  = 0;
        dst_stall_pct = 0;
        rx_hold_len   = 0;
        cycle_count   = 0;
        error_count   = 0;
        set_window(swa_pkg::WIN_CFG_W'(swa_pkg::WIN_RESET));
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_window();
        test_window_edges();
        test_random_traffic(28, 86);
        test_random_traffic(86, 28);
        test_random_traffic(0, 0);
        test_backpressure();

        wait_results_drained();
        repeat (40) @(posedge aclk);
        if (error_count == 0 && avg_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

/* sim.f */
src/swa_pkg.sv
src/swa_store.sv
src/swa_divider.sv
src/sliding_window_average.sv
sim/tb_top.sv
